// File: design/rva_pkg.sv
package rva_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int CORDIC_N = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
	// reduce, fold, CORDIC stages, round
	localparam int CS_LAT = CORDIC_N + 3;

	localparam int AW = 37;
	localparam int ZW = 35;
	localparam int XW = 34;
	localparam int CW = 20;

	localparam logic signed [AW-1:0] Q30_PI = 37'sd3373259426;
	localparam logic signed [AW-1:0] Q30_TWO_PI = 37'sd6746518852;
	localparam logic signed [AW-1:0] Q30_HALF_PI = 37'sd1686629713;
	localparam logic signed [XW-1:0] Q30_GAIN = 34'sd652032874;

	localparam logic signed [ZW-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
		35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159, 35'sd67021687,
		35'sd33543516, 35'sd16775851, 35'sd8388437, 35'sd4194283, 35'sd2097149,
		35'sd1048576, 35'sd524288, 35'sd262144, 35'sd131072, 35'sd65536,
		35'sd32768, 35'sd16384, 35'sd8192, 35'sd4096, 35'sd2048,
		35'sd1024, 35'sd512, 35'sd256, 35'sd128
	};

	typedef struct packed {
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] s;
	} cs_t;

	typedef struct packed {
		logic en;
		logic valid;
	} pipe_ctl_t;

endpackage

// File: design/rva_cordic.sv
module rva_cordic import rva_pkg::*; (
	input logic clk,
	input logic arst_n,
	input pipe_ctl_t ctl,
	input logic signed [20:0] angle,
	output logic valid,
	output cs_t cs
);

	logic signed [AW-1:0] a0;
	logic signed [AW-1:0] ared;
	logic signed [ZW-1:0] a_s1;
	logic v_s1;
	logic signed [ZW-1:0] a_s2;
	logic neg_s2;
	logic v_s2;

	logic signed [XW-1:0] x_s [CORDIC_N+1];
	logic signed [XW-1:0] y_s [CORDIC_N+1];
	logic signed [ZW-1:0] z_s [CORDIC_N+1];
	logic neg_s [CORDIC_N+1];
	logic v_s [CORDIC_N+1];

	logic signed [XW-1:0] xr, yr;
	cs_t cs_s3;
	logic v_s3;

	assign a0 = {{2{angle[20]}}, angle, 14'b0};

	always_comb begin
		ared = a0;
		if (a0 > Q30_PI + 37'sd2 * Q30_TWO_PI)
			ared = a0 - 37'sd3 * Q30_TWO_PI;
		else if (a0 > Q30_PI + Q30_TWO_PI)
			ared = a0 - 37'sd2 * Q30_TWO_PI;
		else if (a0 > Q30_PI)
			ared = a0 - Q30_TWO_PI;
		else if (a0 <= -Q30_PI - 37'sd2 * Q30_TWO_PI)
			ared = a0 + 37'sd3 * Q30_TWO_PI;
		else if (a0 <= -Q30_PI - Q30_TWO_PI)
			ared = a0 + 37'sd2 * Q30_TWO_PI;
		else if (a0 <= -Q30_PI)
			ared = a0 + Q30_TWO_PI;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (ctl.en) begin
			v_s1 <= ctl.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			a_s1 <= ared[ZW-1:0];
			if (a_s1 > ZW'(Q30_HALF_PI)) begin
				a_s2 <= a_s1 - ZW'(Q30_PI);
				neg_s2 <= 1'b1;
			end else if (a_s1 < -ZW'(Q30_HALF_PI)) begin
				a_s2 <= a_s1 + ZW'(Q30_PI);
				neg_s2 <= 1'b1;
			end else begin
				a_s2 <= a_s1;
				neg_s2 <= 1'b0;
			end
		end
	end

	assign x_s[0] = Q30_GAIN;
	assign y_s[0] = '0;
	assign z_s[0] = a_s2;
	assign neg_s[0] = neg_s2;
	assign v_s[0] = v_s2;

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (ctl.en)
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				neg_s[i+1] <= neg_s[i];
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_Q30[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_Q30[i];
				end
			end
		end
	end

	assign xr = (x_s[CORDIC_N] + 34'sd8192) >>> 14;
	assign yr = (y_s[CORDIC_N] + 34'sd8192) >>> 14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (ctl.en)
			v_s3 <= v_s[CORDIC_N];
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			cs_s3.c <= neg_s[CORDIC_N] ? -xr[CW-1:0] : xr[CW-1:0];
			cs_s3.s <= neg_s[CORDIC_N] ? -yr[CW-1:0] : yr[CW-1:0];
		end
	end

	assign valid = v_s3;
	assign cs = cs_s3;

	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (a_s2 <= ZW'(Q30_HALF_PI) && a_s2 >= -ZW'(Q30_HALF_PI)))
		else $error("folded angle outside half pi");

	a_cs_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (cs_s3.c <= 20'sd65600 && cs_s3.c >= -20'sd65600
			&& cs_s3.s <= 20'sd65600 && cs_s3.s >= -20'sd65600))
		else $error("cos or sin beyond unity");

endmodule

// File: design/rva_rotate.sv
module rva_rotate import rva_pkg::*; (
	input logic clk,
	input logic arst_n,
	input pipe_ctl_t ctl,
	input logic signed [31:0] v [3],
	input logic signed [17:0] k [3],
	input cs_t cs,
	output logic valid,
	output logic signed [31:0] r [3],
	output logic sat
);

	logic signed [49:0] p_s1 [3][3];
	logic signed [31:0] v_s1 [3];
	logic signed [17:0] k_s1 [3];
	logic signed [CW-1:0] c_s1, s_s1;
	logic signed [18:0] om_s1;
	logic v1;

	logic signed [51:0] dsum, csum [3];
	logic signed [51:0] dsh, csh [3];
	logic signed [35:0] dot_s2, cr_s2 [3];
	logic signed [31:0] v_s2 [3];
	logic signed [17:0] k_s2 [3];
	logic signed [CW-1:0] c_s2, s_s2;
	logic signed [18:0] om_s2;
	logic v2;

	logic signed [54:0] wp_s3;
	logic signed [51:0] vc_s3 [3];
	logic signed [55:0] cs_s3 [3];
	logic signed [17:0] k_s3 [3];
	logic v3;

	logic signed [54:0] wsh;
	logic signed [38:0] w_s4;
	logic signed [56:0] t_s4 [3];
	logic signed [17:0] k_s4 [3];
	logic v4;

	logic signed [56:0] wk_s5 [3];
	logic signed [56:0] t_s5 [3];
	logic v5;

	logic signed [58:0] fsum [3];
	logic signed [58:0] fsh [3];
	logic signed [31:0] r_s6 [3];
	logic [2:0] clip;
	logic sat_s6;
	logic v6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
			v6 <= 1'b0;
		end else if (ctl.en) begin
			v1 <= ctl.valid;
			v2 <= v1;
			v3 <= v2;
			v4 <= v3;
			v5 <= v4;
			v6 <= v5;
		end
	end

	assign dsum = 52'(p_s1[0][0]) + 52'(p_s1[1][1]) + 52'(p_s1[2][2]) + 52'sd32768;
	assign csum[0] = 52'(p_s1[1][2]) - 52'(p_s1[2][1]) + 52'sd32768;
	assign csum[1] = 52'(p_s1[2][0]) - 52'(p_s1[0][2]) + 52'sd32768;
	assign csum[2] = 52'(p_s1[0][1]) - 52'(p_s1[1][0]) + 52'sd32768;
	assign dsh = dsum >>> 16;
	assign wsh = (wp_s3 + 55'sd32768) >>> 16;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		assign csh[i] = csum[i] >>> 16;
		assign fsum[i] = 59'(t_s5[i]) + 59'(wk_s5[i]) + 59'sd32768;
		assign fsh[i] = fsum[i] >>> 16;
		assign clip[i] = (fsh[i] > 59'sd2147483647) || (fsh[i] < -59'sd2147483648);
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++)
					p_s1[i][j] <= k[i] * v[j];
				v_s1[i] <= v[i];
				k_s1[i] <= k[i];

				cr_s2[i] <= csh[i][35:0];
				v_s2[i] <= v_s1[i];
				k_s2[i] <= k_s1[i];

				vc_s3[i] <= v_s2[i] * c_s2;
				cs_s3[i] <= cr_s2[i] * s_s2;
				k_s3[i] <= k_s2[i];

				t_s4[i] <= 57'(vc_s3[i]) + 57'(cs_s3[i]);
				k_s4[i] <= k_s3[i];

				wk_s5[i] <= w_s4 * k_s4[i];
				t_s5[i] <= t_s4[i];

				if (fsh[i] > 59'sd2147483647)
					r_s6[i] <= 32'sh7fffffff;
				else if (fsh[i] < -59'sd2147483648)
					r_s6[i] <= 32'sh80000000;
				else
					r_s6[i] <= fsh[i][31:0];
			end
			c_s1 <= cs.c;
			s_s1 <= cs.s;
			om_s1 <= 19'sd65536 - 19'(cs.c);

			dot_s2 <= dsh[35:0];
			c_s2 <= c_s1;
			s_s2 <= s_s1;
			om_s2 <= om_s1;

			wp_s3 <= dot_s2 * om_s2;

			w_s4 <= wsh[38:0];

			sat_s6 <= |clip;
		end
	end

	assign valid = v6;
	assign r = r_s6;
	assign sat = sat_s6;

endmodule

// File: design/rotate_vector_about_axis.sv
// Rodrigues rotation of a Q16.16 vector about a Q1.16 axis by a Q4.16 angle in
// radians. The angle is wrapped into (-pi, pi], cosine and sine come from a fully
// pipelined CORDIC, and the products run through a six-stage multiplier pipeline.
// One transaction is accepted every cycle while in_stall is low, that is unless a
// stalled result is held. Components outside the signed 32-bit range are clipped
// and raise saturated. The axis is not normalised.
module rotate_vector_about_axis import rva_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [31:0] vec_x,
	input logic signed [31:0] vec_y,
	input logic signed [31:0] vec_z,
	input logic signed [17:0] axis_x,
	input logic signed [17:0] axis_y,
	input logic signed [17:0] axis_z,
	input logic signed [20:0] angle,
	output logic out_valid,
	input logic out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic saturated
);

	pipe_ctl_t in_ctl, mid_ctl;
	logic en;
	logic cs_valid;
	cs_t cs;
	logic signed [31:0] dv_s [CS_LAT+1][3];
	logic signed [17:0] dk_s [CS_LAT+1][3];
	logic signed [31:0] r [3];

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign in_ctl = '{en: en, valid: in_valid};
	assign mid_ctl = '{en: en, valid: cs_valid};

	assign dv_s[0] = '{vec_x, vec_y, vec_z};
	assign dk_s[0] = '{axis_x, axis_y, axis_z};

	for (genvar i = 0; i < CS_LAT; i++) begin : g_delay
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[i+1] <= dv_s[i];
				dk_s[i+1] <= dk_s[i];
			end
		end
	end

	rva_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(in_ctl),
		.angle(angle),
		.valid(cs_valid),
		.cs(cs)
	);

	rva_rotate u_rotate (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(mid_ctl),
		.v(dv_s[CS_LAT]),
		.k(dk_s[CS_LAT]),
		.cs(cs),
		.valid(out_valid),
		.r(r),
		.sat(saturated)
	);

	assign out_x = r[0];
	assign out_y = r[1];
	assign out_z = r[2];

	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (out_x == 32'sh7fffffff || out_x == 32'sh80000000
			|| out_y == 32'sh7fffffff || out_y == 32'sh80000000
			|| out_z == 32'sh7fffffff || out_z == 32'sh80000000))
		else $error("saturated without a clipped component");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(saturated)))
		else $error("stalled result changed");

endmodule
